/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define DVS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dvs check failed");

// Same, with a caller-supplied message.
`define DVS_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

/* rtl/core/dvs_pkg.sv */
`timescale 1ns / 1ps

package dvs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_ATTEN   = 90;
    localparam int ATTEN_W     = 7;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item queue between front and back
    localparam int ITEMQ_DEPTH = 2;
    localparam int ITEMQ_PTR_W = $clog2(ITEMQ_DEPTH);
    localparam int ITEMQ_CNT_W = $clog2(ITEMQ_DEPTH + 1);

    localparam logic [3:0] KIND_TICK    = 4'd0;
    localparam logic [3:0] KIND_INIT    = 4'd1;
    localparam logic [3:0] KIND_REL     = 4'd2;
    localparam logic [3:0] KIND_ABS     = 4'd3;
    localparam logic [3:0] KIND_MUTE    = 4'd4;
    localparam logic [3:0] KIND_UNMUTE  = 4'd5;
    localparam logic [3:0] KIND_PDOWN   = 4'd6;
    localparam logic [3:0] KIND_PUP     = 4'd7;
    localparam logic [3:0] KIND_GETVOL  = 4'd8;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_DEV   = 2'd1;
    localparam logic [1:0] CFG_GUARD = 2'd2;

    localparam logic [ATTEN_W-1:0] ATTEN_MAX_V = ATTEN_W'(MAX_ATTEN);

    typedef struct packed {
        logic                tick;
        logic                cmd;
        logic [3:0]          kind;
        logic signed [7:0]   amount;
        logic [ATTEN_W-1:0]  abs_atten;
    } t_item;

endpackage

/* rtl/core/dvs_front.sv */
`timescale 1ns / 1ps

module dvs_front (
    input  logic                 i_valid,
    input  logic [3:0]           i_kind,
    input  logic signed [7:0]    i_amount,
    input  logic                 i_full,
    output logic                 o_ready,
    output logic                 o_push,
    output dvs_pkg::t_item       o_item
);

    logic [8:0] w_neg;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // absolute target does not depend on state, so clamp it here
    assign w_neg = 9'd0 - {i_amount[7], i_amount};

    always_comb begin
        o_item.tick   = (i_kind == dvs_pkg::KIND_TICK);
        o_item.cmd    = (i_kind != dvs_pkg::KIND_TICK) && (i_kind <= dvs_pkg::KIND_GETVOL);
        o_item.kind   = i_kind;
        o_item.amount = i_amount;
        if (w_neg[8]) begin
            o_item.abs_atten = '0;
        end else if (w_neg[7:0] > 8'(dvs_pkg::MAX_ATTEN)) begin
            o_item.abs_atten = dvs_pkg::ATTEN_MAX_V;
        end else begin
            o_item.abs_atten = w_neg[dvs_pkg::ATTEN_W-1:0];
        end
    end

endmodule

/* rtl/core/dvs_queue.sv */
`timescale 1ns / 1ps

module dvs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dvs_pkg::t_item    i_item,
    input  logic              i_pop,
    output dvs_pkg::t_item    o_item,
    output logic              o_empty,
    output logic              o_full
);

    dvs_pkg::t_item                   r_mem [dvs_pkg::ITEMQ_DEPTH];
    logic [dvs_pkg::ITEMQ_PTR_W-1:0]  r_wr;
    logic [dvs_pkg::ITEMQ_PTR_W-1:0]  r_rd;
    logic [dvs_pkg::ITEMQ_CNT_W-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == dvs_pkg::ITEMQ_CNT_W'(dvs_pkg::ITEMQ_DEPTH));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/dvs_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dvs_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_empty,
    input  dvs_pkg::t_item          i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_scl,
    output logic                    o_sda,
    output logic                    o_sda_drive,
    output logic                    o_amp_off,
    output logic signed [7:0]       o_volume_db,
    output logic                    o_busy_res,
    output logic                    o_status
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_GUARD   = 4'd1;
    localparam logic [3:0] PH_START   = 4'd2;
    localparam logic [3:0] PH_BLOW    = 4'd3;
    localparam logic [3:0] PH_BDATA   = 4'd4;
    localparam logic [3:0] PH_BHIGH   = 4'd5;
    localparam logic [3:0] PH_ALOW    = 4'd6;
    localparam logic [3:0] PH_ADLOW   = 4'd7;
    localparam logic [3:0] PH_AREL    = 4'd8;
    localparam logic [3:0] PH_AHIGH   = 4'd9;
    localparam logic [3:0] PH_AEND    = 4'd10;
    localparam logic [3:0] PH_ADRV    = 4'd11;
    localparam logic [3:0] PH_STOPCLK = 4'd12;
    localparam logic [3:0] PH_STOP    = 4'd13;

    localparam logic [15:0] T_START = 16'd16;
    localparam logic [15:0] T_BLOW  = 16'd8;
    localparam logic [15:0] T_BDATA = 16'd16;
    localparam logic [15:0] T_BHIGH = 16'd16;
    localparam logic [15:0] T_ALOW  = 16'd8;
    localparam logic [15:0] T_ASHORT = 16'd4;
    localparam logic [15:0] T_AHIGH = 16'd16;
    localparam logic [15:0] T_STOPCLK = 16'd24;
    localparam logic [15:0] T_STOP  = 16'd16;

    localparam logic [7:0] REG_MODE   = 8'h01;
    localparam logic [7:0] REG_CTRL   = 8'h02;
    localparam logic [7:0] REG_VOL    = 8'h03;
    localparam logic [7:0] REG_MIX    = 8'h04;
    localparam logic [7:0] PDN_BIT    = 8'h01;
    localparam logic [7:0] CTRL_VAL   = 8'h80 | 8'h40 | 8'h09;
    localparam logic [7:0] MUTE_BIT   = 8'h80;
    localparam logic [7:0] MIX_VAL    = 8'h00;

    localparam logic [dvs_pkg::ATTEN_W-1:0] ATTEN_RESET = dvs_pkg::ATTEN_W'(20);

    // configuration
    logic [7:0]   r_mode;
    logic [7:0]   r_dev;
    logic [15:0]  r_guard;

    // block state
    logic [dvs_pkg::ATTEN_W-1:0]  r_atten, n_atten;
    logic [15:0]                  r_wq [dvs_pkg::QUEUE_DEPTH];
    logic [15:0]                  n_wq [dvs_pkg::QUEUE_DEPTH];
    logic [dvs_pkg::QCNT_W-1:0]   r_count, n_count;
    logic [3:0]                   r_phase, n_phase;
    logic [1:0]                   r_byte, n_byte;
    logic [2:0]                   r_bit, n_bit;
    logic [15:0]                  r_timer, n_timer;
    logic                         r_scl, n_scl;
    logic                         r_sda, n_sda;
    logic                         r_drv, n_drv;
    logic                         r_amp, n_amp;

    // result register
    logic                         r_out_valid;
    logic                         r_o_scl, r_o_sda, r_o_drv, r_o_amp;
    logic [7:0]                   r_o_vol;
    logic                         r_o_busy, r_o_status;
    logic                         n_status;

    logic                         w_pop;
    logic [7:0]                   w_cur;
    logic [15:0]                  w_guard;
    logic [9:0]                   w_rel;
    logic [dvs_pkg::ATTEN_W-1:0]  w_rel_atten;
    logic [7:0]                   w_atten_b;

    assign w_pop   = !i_empty && (!r_out_valid || i_ready);
    assign o_pop   = w_pop;
    assign w_guard = (r_guard == 16'd0) ? 16'd1 : r_guard;
    assign w_atten_b = {1'b0, r_atten};

    always_comb begin
        unique case (r_byte)
            2'd0:    w_cur = r_dev;
            2'd1:    w_cur = r_wq[0][15:8];
            default: w_cur = r_wq[0][7:0];
        endcase
    end

    // relative step: subtract signed amount, clamp to 0..MAX_ATTEN
    assign w_rel = {3'b000, r_atten} - {{2{i_item.amount[7]}}, i_item.amount};
    always_comb begin
        if (w_rel[9]) begin
            w_rel_atten = '0;
        end else if (w_rel[8:0] > 9'(dvs_pkg::MAX_ATTEN)) begin
            w_rel_atten = dvs_pkg::ATTEN_MAX_V;
        end else begin
            w_rel_atten = w_rel[dvs_pkg::ATTEN_W-1:0];
        end
    end

    always_comb begin
        n_atten  = r_atten;
        n_wq     = r_wq;
        n_count  = r_count;
        n_phase  = r_phase;
        n_byte   = r_byte;
        n_bit    = r_bit;
        n_timer  = r_timer;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_drv    = r_drv;
        n_amp    = r_amp;
        n_status = 1'b0;

        if (w_pop && i_item.tick && (r_count != '0)) begin
            if (r_timer > 16'd1) begin
                n_timer = r_timer - 16'd1;
            end else begin
                unique case (r_phase)
                    PH_GUARD: begin
                        n_byte = '0; n_bit = '0;
                        n_sda = 1'b0; n_phase = PH_START; n_timer = T_START;
                    end
                    PH_START: begin
                        n_scl = 1'b0; n_phase = PH_BLOW; n_timer = T_BLOW;
                    end
                    PH_BLOW: begin
                        n_sda = w_cur[3'd7 - r_bit]; n_phase = PH_BDATA; n_timer = T_BDATA;
                    end
                    PH_BDATA: begin
                        n_scl = 1'b1; n_phase = PH_BHIGH; n_timer = T_BHIGH;
                    end
                    PH_BHIGH: begin
                        n_scl = 1'b0;
                        if (r_bit != 3'd7) begin
                            n_bit = r_bit + 3'd1; n_phase = PH_BLOW; n_timer = T_BLOW;
                        end else begin
                            n_phase = PH_ALOW; n_timer = T_ALOW;
                        end
                    end
                    PH_ALOW: begin
                        n_sda = 1'b0; n_phase = PH_ADLOW; n_timer = T_ASHORT;
                    end
                    PH_ADLOW: begin
                        n_drv = 1'b0; n_phase = PH_AREL; n_timer = T_ASHORT;
                    end
                    PH_AREL: begin
                        n_scl = 1'b1; n_phase = PH_AHIGH; n_timer = T_AHIGH;
                    end
                    PH_AHIGH: begin
                        n_scl = 1'b0; n_phase = PH_AEND; n_timer = T_ASHORT;
                    end
                    PH_AEND: begin
                        n_drv = 1'b1; n_phase = PH_ADRV; n_timer = T_ASHORT;
                    end
                    PH_ADRV: begin
                        if (r_byte < 2'd2) begin
                            n_byte = r_byte + 2'd1; n_bit = '0;
                            n_scl = 1'b0; n_phase = PH_BLOW; n_timer = T_BLOW;
                        end else begin
                            n_scl = 1'b1; n_phase = PH_STOPCLK; n_timer = T_STOPCLK;
                        end
                    end
                    PH_STOPCLK: begin
                        n_sda = 1'b1; n_phase = PH_STOP; n_timer = T_STOP;
                    end
                    default: begin
                        // write done: drop the head entry
                        for (int i = 0; i < dvs_pkg::QUEUE_DEPTH - 1; i++) begin
                            n_wq[i] = r_wq[i + 1];
                        end
                        n_count = r_count - 1'b1;
                        n_byte  = '0;
                        n_bit   = '0;
                        if (r_count != dvs_pkg::QCNT_W'(1)) begin
                            n_phase = PH_GUARD; n_timer = w_guard;
                        end else begin
                            n_phase = PH_IDLE; n_timer = '0;
                        end
                    end
                endcase
            end
        end else if (w_pop && i_item.cmd) begin
            if (r_count != '0) begin
                n_status = 1'b1;
            end else begin
                unique case (i_item.kind)
                    dvs_pkg::KIND_INIT: begin
                        n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b1;
                        n_wq[0] = {REG_MODE, r_mode | PDN_BIT};
                        n_wq[1] = {REG_CTRL, CTRL_VAL};
                        n_wq[2] = {REG_VOL, w_atten_b};
                        n_wq[3] = {REG_MIX, MIX_VAL};
                        n_count = dvs_pkg::QCNT_W'(4);
                    end
                    dvs_pkg::KIND_REL: begin
                        n_atten = w_rel_atten;
                        n_wq[0] = {REG_VOL, 1'b0, w_rel_atten};
                        n_count = dvs_pkg::QCNT_W'(1);
                    end
                    dvs_pkg::KIND_ABS: begin
                        n_atten = i_item.abs_atten;
                        n_wq[0] = {REG_VOL, 1'b0, i_item.abs_atten};
                        n_count = dvs_pkg::QCNT_W'(1);
                    end
                    dvs_pkg::KIND_MUTE: begin
                        n_wq[0] = {REG_VOL, w_atten_b | MUTE_BIT};
                        n_count = dvs_pkg::QCNT_W'(1);
                    end
                    dvs_pkg::KIND_UNMUTE: begin
                        n_wq[0] = {REG_VOL, w_atten_b};
                        n_count = dvs_pkg::QCNT_W'(1);
                    end
                    dvs_pkg::KIND_PDOWN: begin
                        n_wq[0] = {REG_MODE, r_mode | PDN_BIT};
                        n_count = dvs_pkg::QCNT_W'(1);
                        n_amp   = 1'b1;
                    end
                    dvs_pkg::KIND_PUP: begin
                        n_wq[0] = {REG_MODE, r_mode};
                        n_count = dvs_pkg::QCNT_W'(1);
                        n_amp   = 1'b0;
                    end
                    default: begin
                        // get volume: report only
                    end
                endcase
                if (i_item.kind != dvs_pkg::KIND_GETVOL) begin
                    n_phase = PH_GUARD;
                    n_timer = w_guard;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 8'h86;
            r_dev   <= 8'h22;
            r_guard <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dvs_pkg::CFG_MODE:  r_mode  <= i_cfg_data[7:0];
                dvs_pkg::CFG_DEV:   r_dev   <= i_cfg_data[7:0];
                dvs_pkg::CFG_GUARD: r_guard <= i_cfg_data;
                default: begin
                    // unmapped index: drop
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atten     <= ATTEN_RESET;
            r_count     <= '0;
            r_phase     <= PH_IDLE;
            r_byte      <= '0;
            r_bit       <= '0;
            r_timer     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_drv       <= 1'b1;
            r_amp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_atten     <= n_atten;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_byte      <= n_byte;
            r_bit       <= n_bit;
            r_timer     <= n_timer;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_drv       <= n_drv;
            r_amp       <= n_amp;
            r_out_valid <= w_pop || (r_out_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_wq <= n_wq;
        if (w_pop) begin
            r_o_scl    <= n_scl;
            r_o_sda    <= n_sda;
            r_o_drv    <= n_drv;
            r_o_amp    <= n_amp;
            r_o_vol    <= 8'd0 - {1'b0, n_atten};
            r_o_busy   <= (n_count != '0);
            r_o_status <= n_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl       = r_o_scl;
    assign o_sda       = r_o_sda;
    assign o_sda_drive = r_o_drv;
    assign o_amp_off   = r_o_amp;
    assign o_volume_db = $signed(r_o_vol);
    assign o_busy_res  = r_o_busy;
    assign o_status    = r_o_status;

    `DVS_ASSERT(a_idle_iff_empty, i_clk, i_rst_n, (r_count == '0) == (r_phase == PH_IDLE))
    `DVS_ASSERT_MSG(a_ack_released, i_clk, i_rst_n,
        (r_phase == PH_AREL || r_phase == PH_AHIGH || r_phase == PH_AEND) |-> (!r_drv && !r_sda),
        "SDA driven inside ACK slot")
    `DVS_ASSERT_MSG(a_busy_no_change, i_clk, i_rst_n,
        (w_pop && i_item.cmd && r_count != '0) |=> ($stable(r_atten) && $stable(r_amp) && r_o_status),
        "rejected command changed state")

endmodule

/* rtl/core/dac_volume_i2c_write_sequencer.sv */
`timescale 1ns / 1ps

// DAC volume control with a bit-banged register-write sequencer. Each accepted input word
// (a one-microsecond tick or a command) gives exactly one result word carrying the pin levels,
// amplifier-off pin, current volume, busy flag and accept/reject status after that word. The
// block sustains one input word per clock while the result output is not stalled: the front
// classifies the word and pushes it into a two-entry item queue, and the back applies it to the
// volume and pin-sequencer state and loads the output register, so a result passes through the
// item queue and the output register. The back's state update, on which each word depends, sets
// that rate. Commands sent while writes are still pending are rejected with status 1; ticks
// advance the SCL/SDA waveform one count each. Configuration writes are always ready and take
// effect at once; write them only while no word is in flight.
module dac_volume_i2c_write_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_kind,
    input  logic signed [7:0]  i_amount,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_scl,
    output logic               o_sda,
    output logic               o_sda_drive,
    output logic               o_amp_off,
    output logic signed [7:0]  o_volume_db,
    output logic               o_busy_res,
    output logic               o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    dvs_pkg::t_item  w_front_item;
    dvs_pkg::t_item  w_back_item;
    logic            w_push;
    logic            w_pop;
    logic            w_empty;
    logic            w_full;

    assign o_cfg_ready = 1'b1;

    dvs_front u_front (
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_amount (i_amount),
        .i_full   (w_full),
        .o_ready  (o_ready),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    dvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_back_item),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    dvs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (w_empty),
        .i_item      (w_back_item),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_scl       (o_scl),
        .o_sda       (o_sda),
        .o_sda_drive (o_sda_drive),
        .o_amp_off   (o_amp_off),
        .o_volume_db (o_volume_db),
        .o_busy_res  (o_busy_res),
        .o_status    (o_status)
    );

endmodule
